### rtl/bcc_pkg.sv
// shared types and constants of the button click classifier
`timescale 1ns / 1ps
package bcc_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int NOW_W         = 32;
  localparam int CFG_W         = 16;
  localparam int CFG_ADDR_W    = 5;
  localparam int CFG_DATA_W    = 32;
  localparam int EVENT_W       = 3;

  localparam logic [CFG_W-1:0] LONG_PRESS_RST      = 16'd1000;
  localparam logic [CFG_W-1:0] CLICK_WINDOW_RST    = 16'd250;
  localparam logic [CFG_W-1:0] DEBOUNCE_RST        = 16'd5;
  localparam logic [CFG_W-1:0] REPEAT_DELAY_RST    = 16'd3000;
  localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd100;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE    = 3'd0,
    EV_PRESSED = 3'd1,
    EV_CLICK   = 3'd2,
    EV_LONG    = 3'd3,
    EV_DOUBLE  = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    REG_LONG_PRESS      = 3'd0,
    REG_CLICK_WINDOW    = 3'd1,
    REG_DEBOUNCE        = 3'd2,
    REG_REPEAT_DELAY    = 3'd3,
    REG_REPEAT_INTERVAL = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] click_window_ms;
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] repeat_delay_ms;
    logic [CFG_W-1:0] repeat_interval_ms;
  } cfg_t;

endpackage

### rtl/bcc_sample_if.sv
// input channel: one switch sample with its timestamp
`timescale 1ns / 1ps
interface bcc_sample_if;
  logic                     valid;
  logic                     ready;
  logic                     switch_level;
  logic [bcc_pkg::NOW_W-1:0] now_ms;

  modport source (output valid, output switch_level, output now_ms, input ready);
  modport sink (input valid, input switch_level, input now_ms, output ready);
endinterface

### rtl/bcc_event_if.sv
// output channel: one event code per sample
`timescale 1ns / 1ps
interface bcc_event_if;
  logic                       valid;
  logic                       ready;
  logic [bcc_pkg::EVENT_W-1:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink (input valid, input event_code, output ready);
endinterface

### rtl/bcc_cfg_regs.sv
// apb configuration registers of the classifier
`timescale 1ns / 1ps
module bcc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bcc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bcc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bcc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output bcc_pkg::cfg_t                  cfg
);

  bcc_pkg::reg_index_t         index;
  logic                        wr_en;
  logic [bcc_pkg::CFG_W-1:0]   wr_val;
  logic [bcc_pkg::CFG_W-1:0]   rd_val;

  // word addressed, byte lanes ignored
  assign index  = bcc_pkg::reg_index_t'(paddr[bcc_pkg::CFG_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_val = pwdata[bcc_pkg::CFG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ms      <= bcc_pkg::LONG_PRESS_RST;
      cfg.click_window_ms    <= bcc_pkg::CLICK_WINDOW_RST;
      cfg.debounce_ms        <= bcc_pkg::DEBOUNCE_RST;
      cfg.repeat_delay_ms    <= bcc_pkg::REPEAT_DELAY_RST;
      cfg.repeat_interval_ms <= bcc_pkg::REPEAT_INTERVAL_RST;
    end else if (wr_en) begin
      unique case (index)
        bcc_pkg::REG_LONG_PRESS:      cfg.long_press_ms      <= wr_val;
        bcc_pkg::REG_CLICK_WINDOW:    cfg.click_window_ms    <= wr_val;
        bcc_pkg::REG_DEBOUNCE:        cfg.debounce_ms        <= wr_val;
        bcc_pkg::REG_REPEAT_DELAY:    cfg.repeat_delay_ms    <= wr_val;
        bcc_pkg::REG_REPEAT_INTERVAL: cfg.repeat_interval_ms <= wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      bcc_pkg::REG_LONG_PRESS:      rd_val = cfg.long_press_ms;
      bcc_pkg::REG_CLICK_WINDOW:    rd_val = cfg.click_window_ms;
      bcc_pkg::REG_DEBOUNCE:        rd_val = cfg.debounce_ms;
      bcc_pkg::REG_REPEAT_DELAY:    rd_val = cfg.repeat_delay_ms;
      bcc_pkg::REG_REPEAT_INTERVAL: rd_val = cfg.repeat_interval_ms;
      default:                      rd_val = '0;
    endcase
  end

  assign prdata = bcc_pkg::CFG_DATA_W'(rd_val);

endmodule

### rtl/bcc_classify.sv
// classifier state and the per-sample decision logic
`timescale 1ns / 1ps
module bcc_classify #(
  parameter int TIME_BITS = bcc_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bcc_pkg::cfg_t               cfg,
  input  logic                        en,
  input  logic                        level,
  input  logic [bcc_pkg::NOW_W-1:0]   now_ms,
  output bcc_pkg::event_t             ev_next
);

  logic                  accepted_level, accepted_level_next;
  logic [TIME_BITS-1:0]  change_stamp, change_stamp_next;
  logic [TIME_BITS-1:0]  press_stamp, press_stamp_next;
  logic [TIME_BITS-1:0]  repeat_stamp, repeat_stamp_next;
  logic                  press_pending, press_pending_next;
  logic                  second_press_seen, second_press_seen_next;
  bcc_pkg::event_t       current_event;

  logic [TIME_BITS-1:0]  now;
  logic [TIME_BITS-1:0]  el_change, el_press, el_repeat;
  logic [TIME_BITS-1:0]  long_t, window_t, deb_t, rdelay_t, rint_t;
  logic                  changed, new_press;

  assign now       = TIME_BITS'(now_ms);
  assign long_t    = TIME_BITS'(cfg.long_press_ms);
  assign window_t  = TIME_BITS'(cfg.click_window_ms);
  assign deb_t     = TIME_BITS'(cfg.debounce_ms);
  assign rdelay_t  = TIME_BITS'(cfg.repeat_delay_ms);
  assign rint_t    = TIME_BITS'(cfg.repeat_interval_ms);

  // wrapping differences
  assign el_change = now - change_stamp;
  assign el_press  = now - press_stamp;
  assign el_repeat = now - repeat_stamp;
  assign changed   = level != accepted_level;
  assign new_press = !press_pending && accepted_level;

  always_comb begin
    accepted_level_next    = accepted_level;
    change_stamp_next      = change_stamp;
    press_stamp_next       = press_stamp;
    repeat_stamp_next      = repeat_stamp;
    press_pending_next     = press_pending;
    second_press_seen_next = second_press_seen;
    ev_next                = current_event;
    if (changed && (el_change < deb_t)) begin
      // bounce: nothing moves, last event repeats
      ev_next = current_event;
    end else begin
      if (changed) change_stamp_next = now;
      if (!level) begin
        if (press_pending && accepted_level) second_press_seen_next = 1'b1;
        if (new_press) begin
          press_stamp_next   = now;
          repeat_stamp_next  = now;
          press_pending_next = 1'b1;
        end
        // a fresh press has zero elapsed time, so no repeat yet
        if (!new_press && (el_press > rdelay_t) && (el_repeat > rint_t)) begin
          ev_next           = bcc_pkg::EV_CLICK;
          repeat_stamp_next = now;
        end else begin
          ev_next = bcc_pkg::EV_PRESSED;
        end
        accepted_level_next = 1'b0;
      end else begin
        priority if (press_pending && (el_press > long_t) && !second_press_seen) begin
          ev_next             = bcc_pkg::EV_LONG;
          accepted_level_next = 1'b1;
          press_pending_next  = 1'b0;
        end else if (press_pending && (el_press > window_t)) begin
          ev_next = second_press_seen ? bcc_pkg::EV_DOUBLE : bcc_pkg::EV_CLICK;
          accepted_level_next    = 1'b1;
          press_pending_next     = 1'b0;
          second_press_seen_next = 1'b0;
        end else if (press_pending) begin
          // inside the click window: wait for a second press
          accepted_level_next = 1'b1;
        end else begin
          ev_next = bcc_pkg::EV_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_level    <= 1'b1;
      change_stamp      <= '0;
      press_stamp       <= '0;
      repeat_stamp      <= '0;
      press_pending     <= 1'b0;
      second_press_seen <= 1'b0;
      current_event     <= bcc_pkg::EV_NONE;
    end else if (en) begin
      accepted_level    <= accepted_level_next;
      change_stamp      <= change_stamp_next;
      press_stamp       <= press_stamp_next;
      repeat_stamp      <= repeat_stamp_next;
      press_pending     <= press_pending_next;
      second_press_seen <= second_press_seen_next;
      current_event     <= ev_next;
    end
  end

endmodule

### rtl/button_click_classifier_unit.sv
// top level of the button click classifier
`timescale 1ns / 1ps
// Classifies scan samples of an active-low button (level plus millisecond
// timestamp) into one event code per sample: none, pressed, click, long
// click or double click, with debounce and auto-repeat while held. One
// sample is taken every clock cycle while the output is not stalled; a
// result is registered once its sample moves from the input register
// through the state update into the result register, and it holds there
// for as long as the output is stalled. Stamps are kept TIME_BITS wide
// and all time differences wrap at that width. Five 16-bit registers sit
// at byte addresses 0, 4, 8, 12 and 16 of the APB port: long press, click
// window, debounce, repeat delay, repeat interval.
module button_click_classifier_unit #(
  parameter int TIME_BITS = bcc_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  bcc_sample_if.sink                     sample,
  bcc_event_if.source                    result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bcc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bcc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bcc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  bcc_pkg::cfg_t               cfg;
  logic                        s1_valid;
  logic                        s1_level;
  logic [bcc_pkg::NOW_W-1:0]   s1_now;
  logic                        s1_adv;
  logic                        res_valid;
  bcc_pkg::event_t             res_code;
  bcc_pkg::event_t             ev_next;

  bcc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bcc_classify #(
    .TIME_BITS (TIME_BITS)
  ) u_classify (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .en      (s1_adv),
    .level   (s1_level),
    .now_ms  (s1_now),
    .ev_next (ev_next)
  );

  // stage moves on when the result register is free or being drained
  assign s1_adv       = s1_valid && (!res_valid || result.ready);
  assign sample.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_level <= sample.switch_level;
      s1_now   <= sample.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_code <= ev_next;
    end
  end

  assign result.valid      = res_valid;
  assign result.event_code = res_code;

  // an accepted sample always lands in the input stage
  a_stage_fill: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> s1_valid)
    else $error("accepted sample did not reach the input stage");

  // a blocked stage keeps its sample
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_now) && $stable(s1_level)))
    else $error("blocked input stage lost its sample");

  // draining the result with nothing behind it empties the output
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (res_valid && result.ready && !s1_valid) |=> !res_valid)
    else $error("result repeated after transaction");

endmodule

### tb/sv/tb_button_click_classifier_unit.sv
// self-checking testbench of the button click classifier: scan script, random gestures, apb setup
`timescale 1ns / 1ps
module tb_button_click_classifier_unit;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 175;
  localparam int NUM_PHASES     = 6;
  localparam int MAX_REPORTS    = 10;
  localparam int SCRIPT_ROWS    = 24;
  localparam int DRAIN_CYCLES   = 8;

  // addresses past the last register, writes there must change nothing
  localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

  typedef logic [bcc_pkg::CFG_W-1:0] cfg_word_t;
  typedef logic [bcc_pkg::CFG_DATA_W-bcc_pkg::CFG_W-1:0] pad_t;

  typedef struct packed {
    logic                      level;
    logic [bcc_pkg::NOW_W-1:0] now;
    logic                      typed;
    bcc_pkg::event_t           code;
  } scan_row_t;

  typedef struct packed {
    logic            typed;
    bcc_pkg::event_t code;
  } typed_code_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [bcc_pkg::CFG_ADDR_W-1:0] paddr;
  logic [bcc_pkg::CFG_DATA_W-1:0] pwdata;
  logic [bcc_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  bcc_sample_if sample_ch ();
  bcc_event_if  result_ch ();

  button_click_classifier_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // classifier mirror: registers and state
  bcc_pkg::cfg_t             cfg_mirror;
  logic                      held_level;
  logic [bcc_pkg::NOW_W-1:0] change_at;
  logic [bcc_pkg::NOW_W-1:0] press_at;
  logic [bcc_pkg::NOW_W-1:0] repeat_at;
  logic                      press_open;
  logic                      second_press;
  bcc_pkg::event_t           last_event;

  bcc_pkg::event_t           pending_events [$];
  typed_code_t               script_codes [$];
  logic [bcc_pkg::NOW_W-1:0] clock_ms;

  int send_idle_pct = 28;
  int recv_idle_pct = 65;
  int mismatches = 0;
  int samples_taken = 0;
  int results_checked = 0;
  int items_sent = 0;
  int writes_done = 0;
  int stall_cycles = 0;
  int event_mix [0:7];

  // press and release walk-through at reset settings, ends across the time wrap
  scan_row_t scan_script [0:SCRIPT_ROWS-1] = '{
    '{1'b1, 32'd0,          1'b1, bcc_pkg::EV_NONE},
    '{1'b0, 32'd3,          1'b1, bcc_pkg::EV_NONE},
    '{1'b0, 32'd10,         1'b1, bcc_pkg::EV_PRESSED},
    '{1'b0, 32'd50,         1'b1, bcc_pkg::EV_PRESSED},
    '{1'b1, 32'd52,         1'b0, bcc_pkg::EV_NONE},
    '{1'b0, 32'd100,        1'b0, bcc_pkg::EV_NONE},
    '{1'b1, 32'd200,        1'b0, bcc_pkg::EV_NONE},
    '{1'b1, 32'd300,        1'b0, bcc_pkg::EV_NONE},
    '{1'b1, 32'd301,        1'b0, bcc_pkg::EV_NONE},
    '{1'b0, 32'd1000,       1'b0, bcc_pkg::EV_NONE},
    '{1'b1, 32'd2500,       1'b0, bcc_pkg::EV_NONE},
    '{1'b0, 32'd3000,       1'b0, bcc_pkg::EV_NONE},
    '{1'b0, 32'd6001,       1'b0, bcc_pkg::EV_NONE},
    '{1'b0, 32'd6050,       1'b0, bcc_pkg::EV_NONE},
    '{1'b0, 32'd6102,       1'b0, bcc_pkg::EV_NONE},
    '{1'b1, 32'd6200,       1'b0, bcc_pkg::EV_NONE},
    '{1'b0, 32'd7000,       1'b0, bcc_pkg::EV_NONE},
    '{1'b1, 32'd7100,       1'b0, bcc_pkg::EV_NONE},
    '{1'b1, 32'd7300,       1'b0, bcc_pkg::EV_NONE},
    '{1'b0, 32'hFFFF_FFF0,  1'b0, bcc_pkg::EV_NONE},
    '{1'b1, 32'h0000_0190,  1'b0, bcc_pkg::EV_NONE},
    '{1'b0, 32'hFFFF_FFFF,  1'b0, bcc_pkg::EV_NONE},
    '{1'b1, 32'hFFFF_FFFF,  1'b0, bcc_pkg::EV_NONE},
    '{1'b1, 32'h0000_0400,  1'b0, bcc_pkg::EV_NONE}
  };

  function automatic bcc_pkg::event_t classify_sample(input logic level,
                                                      input logic [bcc_pkg::NOW_W-1:0] now);
    logic [bcc_pkg::NOW_W-1:0] since_change;
    logic [bcc_pkg::NOW_W-1:0] since_press;
    logic [bcc_pkg::NOW_W-1:0] since_repeat;
    since_change = now - change_at;
    // a change too soon after the last accepted one leaves everything alone
    if (level != held_level && since_change < cfg_mirror.debounce_ms) return last_event;
    if (level != held_level) change_at = now;
    if (!level) begin
      if (press_open && held_level) second_press = 1'b1;
      if (!press_open && held_level) begin
        press_at   = now;
        repeat_at  = now;
        press_open = 1'b1;
      end
      since_press  = now - press_at;
      since_repeat = now - repeat_at;
      if (since_press > cfg_mirror.repeat_delay_ms &&
          since_repeat > cfg_mirror.repeat_interval_ms) begin
        last_event = bcc_pkg::EV_CLICK;
        repeat_at  = now;
      end else begin
        last_event = bcc_pkg::EV_PRESSED;
      end
      held_level = 1'b0;
      return last_event;
    end
    since_press = now - press_at;
    if (press_open && since_press > cfg_mirror.long_press_ms && !second_press) begin
      last_event = bcc_pkg::EV_LONG;
      held_level = 1'b1;
      press_open = 1'b0;
    end else if (press_open && since_press > cfg_mirror.click_window_ms) begin
      last_event   = second_press ? bcc_pkg::EV_DOUBLE : bcc_pkg::EV_CLICK;
      held_level   = 1'b1;
      press_open   = 1'b0;
      second_press = 1'b0;
    end else if (press_open) begin
      // released inside the click window: keep waiting for a second press
      held_level = 1'b1;
    end else begin
      last_event = bcc_pkg::EV_NONE;
    end
    return last_event;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch in %s: expected %0d, got %0d", what, want, got);
  endtask

  always @(posedge clk) begin : sample_monitor
    typed_code_t     row_code;
    bcc_pkg::event_t code;
    if (!rst && sample_ch.valid && sample_ch.ready) begin
      code     = classify_sample(sample_ch.switch_level, sample_ch.now_ms);
      row_code = script_codes.pop_front();
      pending_events.push_back(row_code.typed ? row_code.code : code);
      samples_taken++;
    end
  end

  always @(posedge clk) begin : event_checker
    bcc_pkg::event_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (result_ch.valid && result_ch.ready) begin
        event_mix[result_ch.event_code]++;
        if (pending_events.size() == 0) begin
          report_mismatch("event code with nothing pending", 32'd0,
                          32'(result_ch.event_code));
        end else begin
          want = pending_events.pop_front();
          results_checked++;
          if (result_ch.event_code !== want)
            report_mismatch("event code", 32'(want), 32'(result_ch.event_code));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("no transaction for %0d cycles, giving up", stall_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_sample(input logic level, input logic [bcc_pkg::NOW_W-1:0] now,
                             input logic typed, input bcc_pkg::event_t code);
    typed_code_t entry;
    if ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    entry.typed = typed;
    entry.code  = code;
    script_codes.push_back(entry);
    sample_ch.valid        <= 1'b1;
    sample_ch.switch_level <= level;
    sample_ch.now_ms       <= now;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // stop the sample stream and wait for every pending event to come back
  task automatic settle_pipeline();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input cfg_word_t value);
    pad_t junk;
    junk = pad_t'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      bcc_pkg::REG_LONG_PRESS:      cfg_mirror.long_press_ms      = value;
      bcc_pkg::REG_CLICK_WINDOW:    cfg_mirror.click_window_ms    = value;
      bcc_pkg::REG_DEBOUNCE:        cfg_mirror.debounce_ms        = value;
      bcc_pkg::REG_REPEAT_DELAY:    cfg_mirror.repeat_delay_ms    = value;
      bcc_pkg::REG_REPEAT_INTERVAL: cfg_mirror.repeat_interval_ms = value;
      default: ;
    endcase
    writes_done++;
  endtask

  task automatic cfg_readback(input bcc_pkg::reg_index_t idx);
    cfg_word_t want;
    case (idx)
      bcc_pkg::REG_LONG_PRESS:   want = cfg_mirror.long_press_ms;
      bcc_pkg::REG_CLICK_WINDOW: want = cfg_mirror.click_window_ms;
      bcc_pkg::REG_DEBOUNCE:     want = cfg_mirror.debounce_ms;
      bcc_pkg::REG_REPEAT_DELAY: want = cfg_mirror.repeat_delay_ms;
      default:                   want = cfg_mirror.repeat_interval_ms;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {{(bcc_pkg::CFG_DATA_W-bcc_pkg::CFG_W){1'b0}}, want})
      report_mismatch("register readback", 32'(want), 32'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input cfg_word_t long_ms, input cfg_word_t window_ms,
                              input cfg_word_t debounce, input cfg_word_t delay_ms,
                              input cfg_word_t interval_ms);
    cfg_write(bcc_pkg::REG_LONG_PRESS, long_ms);
    cfg_write(bcc_pkg::REG_CLICK_WINDOW, window_ms);
    cfg_write(bcc_pkg::REG_DEBOUNCE, debounce);
    cfg_write(bcc_pkg::REG_REPEAT_DELAY, delay_ms);
    cfg_write(bcc_pkg::REG_REPEAT_INTERVAL, interval_ms);
  endtask

  // one press/hold/release gesture with random timing, or a burst of line noise
  task automatic run_gesture();
    int kind;
    int deb;
    int win;
    int lng;
    int dly;
    int ivl;
    int target;
    int hops;
    kind = $urandom_range(0, 9);
    deb  = int'(cfg_mirror.debounce_ms);
    win  = int'(cfg_mirror.click_window_ms);
    lng  = int'(cfg_mirror.long_press_ms);
    dly  = int'(cfg_mirror.repeat_delay_ms);
    ivl  = int'(cfg_mirror.repeat_interval_ms);
    if (kind == 0) begin
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(3) == 0) clock_ms = $urandom;
        else clock_ms += $urandom_range(0, deb + 3);
        send_sample(1'($urandom_range(1)), clock_ms, 1'b0, bcc_pkg::EV_NONE);
      end
    end else begin
      case (kind % 4)
        0:       target = $urandom_range(0, win);
        1:       target = $urandom_range(win, win + lng / 2 + 1);
        2:       target = $urandom_range(lng, lng + lng / 2 + 2);
        default: target = dly;
      endcase
      clock_ms += deb + $urandom_range(0, 2);
      send_sample(1'b0, clock_ms, 1'b0, bcc_pkg::EV_NONE);
      hops = $urandom_range(1, 4);
      repeat (hops) begin
        // contact bounce, mostly inside the debounce time
        if ($urandom_range(5) == 0)
          send_sample(1'b1, clock_ms + $urandom_range(0, deb), 1'b0, bcc_pkg::EV_NONE);
        clock_ms += target / hops + $urandom_range(0, 2);
        send_sample(1'b0, clock_ms, 1'b0, bcc_pkg::EV_NONE);
      end
      if (kind % 4 == 3) begin
        repeat ($urandom_range(2, 8)) begin
          clock_ms += $urandom_range(ivl / 2, ivl * 2 + 2);
          send_sample(1'b0, clock_ms, 1'b0, bcc_pkg::EV_NONE);
        end
      end
      clock_ms += $urandom_range(0, deb + 2);
      send_sample(1'b1, clock_ms, 1'b0, bcc_pkg::EV_NONE);
      if ($urandom_range(2) == 0) begin
        clock_ms += $urandom_range(deb, deb + win / 2 + 1);
        send_sample(1'b0, clock_ms, 1'b0, bcc_pkg::EV_NONE);
        clock_ms += $urandom_range(deb, deb + win / 2 + 1);
        send_sample(1'b1, clock_ms, 1'b0, bcc_pkg::EV_NONE);
      end
      repeat ($urandom_range(1, 3)) begin
        clock_ms += $urandom_range(0, 2 * win + 2);
        send_sample(1'b1, clock_ms, 1'b0, bcc_pkg::EV_NONE);
      end
    end
  endtask

  initial begin : stimulus
    int phase_start;
    sample_ch.valid        = 1'b0;
    sample_ch.switch_level = 1'b1;
    sample_ch.now_ms       = '0;
    result_ch.ready        = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    foreach (event_mix[k]) event_mix[k] = 0;
    cfg_mirror   = '{bcc_pkg::LONG_PRESS_RST, bcc_pkg::CLICK_WINDOW_RST,
                     bcc_pkg::DEBOUNCE_RST, bcc_pkg::REPEAT_DELAY_RST,
                     bcc_pkg::REPEAT_INTERVAL_RST};
    held_level   = 1'b1;
    change_at    = '0;
    press_at     = '0;
    repeat_at    = '0;
    press_open   = 1'b0;
    second_press = 1'b0;
    last_event   = bcc_pkg::EV_NONE;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r <= bcc_pkg::REG_REPEAT_INTERVAL; r++)
      cfg_readback(bcc_pkg::reg_index_t'(r));
    for (int i = 0; i < SCRIPT_ROWS; i++)
      send_sample(scan_script[i].level, scan_script[i].now, scan_script[i].typed,
                  scan_script[i].code);
    settle_pipeline();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase / 2)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (phase)
        0: apply_config(bcc_pkg::LONG_PRESS_RST, bcc_pkg::CLICK_WINDOW_RST,
                        bcc_pkg::DEBOUNCE_RST, bcc_pkg::REPEAT_DELAY_RST,
                        bcc_pkg::REPEAT_INTERVAL_RST);
        1: apply_config(16'd40, 16'd15, 16'd3, 16'd60, 16'd7);
        2: apply_config('0, '0, '0, '0, '0);
        3: apply_config('1, '1, '1, '1, '1);
        4: begin
          apply_config(cfg_word_t'($urandom_range(0, 2000)),
                       cfg_word_t'($urandom_range(0, 2000)),
                       cfg_word_t'($urandom_range(0, 50)),
                       cfg_word_t'($urandom_range(0, 2000)),
                       cfg_word_t'($urandom_range(0, 200)));
          cfg_write(REG_SPARE_FIRST, cfg_word_t'($urandom));
          cfg_write(REG_SPARE_LAST, cfg_word_t'($urandom));
        end
        default: apply_config(cfg_word_t'($urandom_range(0, 120)),
                              cfg_word_t'($urandom_range(0, 120)),
                              cfg_word_t'($urandom_range(0, 10)),
                              cfg_word_t'($urandom_range(0, 120)),
                              cfg_word_t'($urandom_range(0, 20)));
      endcase
      for (int r = 0; r <= bcc_pkg::REG_REPEAT_INTERVAL; r++)
        cfg_readback(bcc_pkg::reg_index_t'(r));
      clock_ms    = $urandom;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) run_gesture();
      settle_pipeline();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d events from %0d samples under %0d register settings, %0d writes",
             results_checked, samples_taken, NUM_PHASES + 1, writes_done);
    $display("events seen: none %0d, pressed %0d, click %0d, long %0d, double %0d; %0d mismatches",
             event_mix[bcc_pkg::EV_NONE], event_mix[bcc_pkg::EV_PRESSED],
             event_mix[bcc_pkg::EV_CLICK], event_mix[bcc_pkg::EV_LONG],
             event_mix[bcc_pkg::EV_DOUBLE], mismatches);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/bcc_pkg.sv
rtl/bcc_sample_if.sv
rtl/bcc_event_if.sv
rtl/bcc_cfg_regs.sv
rtl/bcc_classify.sv
rtl/button_click_classifier_unit.sv
tb/sv/tb_button_click_classifier_unit.sv
